/* sv/signed_mul_div_round_sat_top_defines.svh */
// Assertion macros shared by the signed multiply-divide block.
`ifndef SIGNED_MUL_DIV_ROUND_SAT_TOP_DEFINES_SVH
`define SIGNED_MUL_DIV_ROUND_SAT_TOP_DEFINES_SVH

// Implication checked only outside reset.
`define SMDRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define SMDRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/smdrs_pkg.sv */
// ----------------------------------------------------------------------------
// smdrs_pkg
// Types and constants of the signed multiply-divide pipeline.
// ----------------------------------------------------------------------------
package smdrs_pkg;

  localparam int ValW        = 64;
  localparam int MulW        = 32;
  localparam int ProdW       = ValW + MulW;
  localparam int BitsPerStage = 2;
  localparam int DivStages   = ProdW / BitsPerStage;

  localparam logic [ValW-1:0] MagLimit = {1'b0, {(ValW-1){1'b1}}};

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             neg;
    logic [ValW-1:0]  divisor;
    logic [ValW-1:0]  rem;
    logic [ProdW-1:0] work;
  } smdrs_div_t;

endpackage

/* sv/signed_mul_div_round_sat_top.sv */
// ----------------------------------------------------------------------------
// signed_mul_div_round_sat_top
// Pipelined signed 64x32 multiply, divide by 64 bits, round and saturate.
// ----------------------------------------------------------------------------
// The block takes one request in every cycle unless the output stalls, and
// each result passes through three stages that form the magnitudes and the
// 96-bit product, 48 division stages that resolve two quotient bits each,
// and two stages that round, saturate and apply the sign. A stalled output
// holds the whole pipeline, so in_stall follows out_stall while a result is waiting.
`include "signed_mul_div_round_sat_top_defines.svh"

module signed_mul_div_round_sat_top
  import smdrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [ValW-1:0] in_value_in,
  input  logic signed [ValW-1:0] in_divisor_in,
  input  logic signed [MulW-1:0] in_multiplier_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [ValW-1:0] out_quotient_out,
  output logic                   out_overflow_flag
);

  logic       en;
  smdrs_div_t stage_d [DivStages+1];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  smdrs_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_value   (in_value_in),
    .in_divisor (in_divisor_in),
    .in_mult    (in_multiplier_in),
    .out_d      (stage_d[0])
  );

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    smdrs_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_d  (stage_d[g]),
      .out_d (stage_d[g+1])
    );
  end

  smdrs_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_d         (stage_d[DivStages]),
    .out_valid    (out_valid),
    .out_quotient (out_quotient_out),
    .out_ovf      (out_overflow_flag)
  );

  `SMDRS_ASSERT_IMP(a_ovf_sat, out_valid && out_overflow_flag,
    out_quotient_out == MagLimit || out_quotient_out == (ValW'(0) - MagLimit),
    "overflow without saturated quotient")
  `SMDRS_ASSERT_IMP(a_no_min, out_valid,
    out_quotient_out != {1'b1, {(ValW-1){1'b0}}}, "quotient reached most negative value")
  `SMDRS_ASSERT_IMP(a_stall_link, out_valid && out_stall, in_stall,
    "input accepted while output is held")
  `SMDRS_ASSERT_NXT(a_rst_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

/* sv/smdrs_mul.sv */
// ----------------------------------------------------------------------------
// smdrs_mul
// Operand magnitudes, split 64x32 product and product sum, three stages.
// ----------------------------------------------------------------------------
module smdrs_mul
  import smdrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [ValW-1:0] in_value,
  input  logic signed [ValW-1:0] in_divisor,
  input  logic signed [MulW-1:0] in_mult,
  output smdrs_div_t             out_d
);

  logic            a_valid_r, a_zero_r, a_neg_r;
  logic [ValW-1:0] a_x_r, a_y_r;
  logic [MulW-1:0] a_m_r;

  logic            b_valid_r, b_zero_r, b_neg_r;
  logic [ValW-1:0] b_y_r, b_p0_r, b_p1_r;

  smdrs_div_t      c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_r.valid   <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      c_r.valid   <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero_r <= (in_value == '0) || (in_divisor == '0) || (in_mult == '0);
      a_neg_r  <= in_value[ValW-1] ^ in_divisor[ValW-1] ^ in_mult[MulW-1];
      a_x_r    <= in_value[ValW-1] ? (ValW'(0) - in_value) : in_value;
      a_y_r    <= in_divisor[ValW-1] ? (ValW'(0) - in_divisor) : in_divisor;
      a_m_r    <= in_mult[MulW-1] ? (MulW'(0) - in_mult) : in_mult;

      b_zero_r <= a_zero_r;
      b_neg_r  <= a_neg_r;
      b_y_r    <= a_y_r;
      b_p0_r   <= {{MulW{1'b0}}, a_x_r[MulW-1:0]} * {{MulW{1'b0}}, a_m_r};
      b_p1_r   <= {{MulW{1'b0}}, a_x_r[ValW-1:MulW]} * {{MulW{1'b0}}, a_m_r};

      c_r.zero    <= b_zero_r;
      c_r.neg     <= b_neg_r;
      c_r.divisor <= b_y_r;
      c_r.rem     <= '0;
      c_r.work    <= {{MulW{1'b0}}, b_p0_r} + {b_p1_r, {MulW{1'b0}}};
    end
  end

  assign out_d = c_r;

endmodule

/* sv/smdrs_div_stage.sv */
// ----------------------------------------------------------------------------
// smdrs_div_stage
// One registered stage of restoring division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module smdrs_div_stage
  import smdrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  smdrs_div_t in_d,
  output smdrs_div_t out_d
);

  smdrs_div_t d_r;
  smdrs_div_t d_nxt;

  always_comb begin
    logic [ValW:0] r;
    d_nxt = in_d;
    for (int i = 0; i < BitsPerStage; i++) begin
      r = {d_nxt.rem, d_nxt.work[ProdW-1]};
      if (r >= {1'b0, d_nxt.divisor}) begin
        r = r - {1'b0, d_nxt.divisor};
        d_nxt.work = {d_nxt.work[ProdW-2:0], 1'b1};
      end else begin
        d_nxt.work = {d_nxt.work[ProdW-2:0], 1'b0};
      end
      d_nxt.rem = r[ValW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.zero    <= d_nxt.zero;
      d_r.neg     <= d_nxt.neg;
      d_r.divisor <= d_nxt.divisor;
      d_r.rem     <= d_nxt.rem;
      d_r.work    <= d_nxt.work;
    end
  end

  assign out_d = d_r;

endmodule

/* sv/smdrs_out.sv */
// ----------------------------------------------------------------------------
// smdrs_out
// Round half up, then saturate and apply the sign in the output register.
// ----------------------------------------------------------------------------
module smdrs_out
  import smdrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  smdrs_div_t      in_d,
  output logic            out_valid,
  output logic [ValW-1:0] out_quotient,
  output logic            out_ovf
);

  logic             r_valid_r, r_zero_r, r_neg_r;
  logic [ProdW-1:0] r_q_r;
  logic             o_valid_r, o_ovf_r;
  logic [ValW-1:0]  o_q_r;
  logic             inc;
  logic             ovf;
  logic [ValW-1:0]  mag;

  assign inc = {in_d.rem, 1'b0} >= {1'b0, in_d.divisor};
  assign ovf = (r_q_r[ProdW-1:ValW-1] != '0);
  assign mag = ovf ? MagLimit : r_q_r[ValW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      r_valid_r <= in_d.valid;
      o_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_zero_r <= in_d.zero;
      r_neg_r  <= in_d.neg;
      r_q_r    <= in_d.work + {{(ProdW-1){1'b0}}, inc};
      o_ovf_r  <= !r_zero_r && ovf;
      o_q_r    <= r_zero_r ? '0 : (r_neg_r ? (ValW'(0) - mag) : mag);
    end
  end

  assign out_valid    = o_valid_r;
  assign out_quotient = o_q_r;
  assign out_ovf      = o_ovf_r;

endmodule
